// ----- hw/rtl/mcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mcfa_pkg: shared types and codes of the motor command frame acceptor
// Item and result layouts, configuration set, result and status codes.
// ----------------------------------------------------------------------------
package mcfa_pkg;

  localparam int unsigned IdW       = 11;
  localparam int unsigned LenW      = 4;
  localparam int unsigned SeqW      = 16;
  localparam int unsigned TargetW   = 16;
  localparam int unsigned TickW     = 16;
  localparam int unsigned CntW      = 32;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 64;

  localparam logic [TickW-1:0] TickMax = '1;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RES_NONE         = 3'd0,
    RES_ACCEPTED     = 3'd1,
    RES_DUPLICATE    = 3'd2,
    RES_OUT_OF_ORDER = 3'd3,
    RES_DISABLE      = 3'd4
  } frame_result_e;

  typedef enum logic [1:0] {
    COMM_OK      = 2'd0,
    COMM_STALE   = 2'd1,
    COMM_TIMEOUT = 2'd2
  } comm_e;

  typedef enum logic {
    MODE_CURRENT = 1'b0,
    MODE_SPEED   = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    SEQ_PASS = 2'd0,
    SEQ_DUP  = 2'd2,
    SEQ_OOO  = 2'd3
  } seq_verdict_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WHEEL_ID  = 3'd0,
    CFG_SPEED_ID  = 3'd1,
    CFG_ENABLE    = 3'd2,
    CFG_CLEAR0    = 3'd3,
    CFG_CLEAR1    = 3'd4,
    CFG_TIMEOUT   = 3'd5,
    CFG_STALE     = 3'd6,
    CFG_FRAME_LEN = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]   wheel_cmd_id;
    logic [IdW-1:0]   speed_cmd_id;
    logic [7:0]       enable_mask;
    logic [7:0]       clear0_mask;
    logic [7:0]       clear1_mask;
    logic [TickW-1:0] timeout_ticks;
    logic [TickW-1:0] stale_ticks;
    logic [LenW-1:0]  frame_length;
  } cfg_t;

  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] frame_id;
    logic [LenW-1:0] frame_len;
    logic [31:0]    payload_low;
    logic [31:0]    payload_high;
  } item_t;

  typedef struct packed {
    frame_result_e      frame_result;
    logic               ack_request;
    mode_e              motor_mode;
    comm_e              comm_status;
    logic               command_active;
    logic [TargetW-1:0] motor0_target;
    logic [TargetW-1:0] motor1_target;
    logic [SeqW-1:0]    active_sequence;
    logic               force_zero;
    logic               reset_all;
    logic [1:0]         reset_speed_mask;
    logic [1:0]         clear_fault_mask;
  } result_t;

endpackage

// ----- hw/rtl/mcfa_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mcfa_cfg_regs: configuration register bank
// Write-only registers, indexed writes, reset to the default frame setup.
// ----------------------------------------------------------------------------
module mcfa_cfg_regs
  import mcfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_WHEEL_ID:  cfg_d.wheel_cmd_id  = cfg_wdata_i[IdW-1:0];
        CFG_SPEED_ID:  cfg_d.speed_cmd_id  = cfg_wdata_i[IdW-1:0];
        CFG_ENABLE:    cfg_d.enable_mask   = cfg_wdata_i[7:0];
        CFG_CLEAR0:    cfg_d.clear0_mask   = cfg_wdata_i[7:0];
        CFG_CLEAR1:    cfg_d.clear1_mask   = cfg_wdata_i[7:0];
        CFG_TIMEOUT:   cfg_d.timeout_ticks = cfg_wdata_i[TickW-1:0];
        CFG_STALE:     cfg_d.stale_ticks   = cfg_wdata_i[TickW-1:0];
        CFG_FRAME_LEN: cfg_d.frame_length  = cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_cmd_id  <= 11'd257;
      cfg_q.speed_cmd_id  <= 11'd258;
      cfg_q.enable_mask   <= 8'd1;
      cfg_q.clear0_mask   <= 8'd1;
      cfg_q.clear1_mask   <= 8'd2;
      cfg_q.timeout_ticks <= 16'd100;
      cfg_q.stale_ticks   <= 16'd20;
      cfg_q.frame_length  <= 4'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/mcfa_seq_check.sv -----
// ----------------------------------------------------------------------------
// mcfa_seq_check: per-channel sequence tracker
// Classifies an incoming sequence against the last one taken and keeps
// duplicate, out-of-order and gap statistics.
// ----------------------------------------------------------------------------
module mcfa_seq_check
  import mcfa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            check_i,   // enabled frame of this channel commits
  input  logic [SeqW-1:0] seq_i,
  output seq_verdict_e    verdict_o
);

  logic [SeqW-1:0] last_q, last_d;
  logic            valid_q, valid_d;
  logic [CntW-1:0] dup_cnt_q, dup_cnt_d;
  logic [CntW-1:0] ooo_cnt_q, ooo_cnt_d;
  logic [CntW-1:0] drop_cnt_q, drop_cnt_d;
  logic [SeqW-1:0] delta;

  // modulo-2^16 distance; upper half means behind the last sequence
  assign delta = seq_i - last_q;

  always_comb begin
    if (!valid_q) begin
      verdict_o = SEQ_PASS;
    end else if (delta == '0) begin
      verdict_o = SEQ_DUP;
    end else if (delta[SeqW-1]) begin
      verdict_o = SEQ_OOO;
    end else begin
      verdict_o = SEQ_PASS;
    end
  end

  always_comb begin
    last_d     = last_q;
    valid_d    = valid_q;
    dup_cnt_d  = dup_cnt_q;
    ooo_cnt_d  = ooo_cnt_q;
    drop_cnt_d = drop_cnt_q;
    if (check_i) begin
      case (verdict_o)
        SEQ_DUP: dup_cnt_d = dup_cnt_q + 1'b1;
        SEQ_OOO: ooo_cnt_d = ooo_cnt_q + 1'b1;
        default: begin
          last_d  = seq_i;
          valid_d = 1'b1;
          if (valid_q && delta > 16'd1) begin
            drop_cnt_d = drop_cnt_q + CntW'(delta - 16'd1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      valid_q    <= 1'b0;
      dup_cnt_q  <= '0;
      ooo_cnt_q  <= '0;
      drop_cnt_q <= '0;
    end else begin
      last_q     <= last_d;
      valid_q    <= valid_d;
      dup_cnt_q  <= dup_cnt_d;
      ooo_cnt_q  <= ooo_cnt_d;
      drop_cnt_q <= drop_cnt_d;
    end
  end

endmodule

// ----- hw/rtl/mcfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcfa_ctrl: command state and per-item decision logic
// Decodes one frame or tick, updates mode, watchdog and stored targets on
// commit, and forms the result item.
// ----------------------------------------------------------------------------
module mcfa_ctrl
  import mcfa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    commit_i,
  input  item_t   item_i,
  output result_t res_o
);

  mode_e              mode_q, mode_d;
  comm_e              comm_q, comm_d;
  logic               active_q, active_d;
  logic [TickW-1:0]   elapsed_q, elapsed_d;
  logic [TargetW-1:0] wheel_t0_q, wheel_t0_d, wheel_t1_q, wheel_t1_d;
  logic [TargetW-1:0] speed_t0_q, speed_t0_d, speed_t1_q, speed_t1_d;
  logic [SeqW-1:0]    wheel_seq_q, wheel_seq_d, speed_seq_q, speed_seq_d;

  logic               is_wheel, is_speed, hit, enabled;
  logic [TargetW-1:0] t0, t1;
  logic [SeqW-1:0]    seq;
  logic [7:0]         flags, clr;
  seq_verdict_e       wheel_verdict, speed_verdict, verdict;
  logic [TickW-1:0]   elapsed_inc;
  logic               do_disable;

  assign t0    = item_i.payload_low[15:0];
  assign t1    = item_i.payload_low[31:16];
  assign seq   = item_i.payload_high[15:0];
  assign flags = item_i.payload_high[23:16];
  assign clr   = item_i.payload_high[31:24];

  // both ids equal: the frame counts as a current command
  assign is_wheel = (item_i.frame_id == cfg_i.wheel_cmd_id);
  assign is_speed = (item_i.frame_id == cfg_i.speed_cmd_id);
  assign hit      = (item_i.op == OP_FRAME) && (is_wheel || is_speed) &&
                    (item_i.frame_len == cfg_i.frame_length);
  assign enabled  = |(flags & cfg_i.enable_mask);

  mcfa_seq_check u_wheel_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .check_i   (commit_i && hit && enabled && is_wheel),
    .seq_i     (seq),
    .verdict_o (wheel_verdict)
  );

  mcfa_seq_check u_speed_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .check_i   (commit_i && hit && enabled && !is_wheel),
    .seq_i     (seq),
    .verdict_o (speed_verdict)
  );

  assign verdict     = is_wheel ? wheel_verdict : speed_verdict;
  assign elapsed_inc = (elapsed_q != TickMax) ? elapsed_q + 1'b1 : elapsed_q;

  always_comb begin
    mode_d      = mode_q;
    comm_d      = comm_q;
    active_d    = active_q;
    elapsed_d   = elapsed_q;
    wheel_t0_d  = wheel_t0_q;
    wheel_t1_d  = wheel_t1_q;
    speed_t0_d  = speed_t0_q;
    speed_t1_d  = speed_t1_q;
    wheel_seq_d = wheel_seq_q;
    speed_seq_d = speed_seq_q;
    do_disable  = 1'b0;

    res_o                  = '0;
    res_o.frame_result     = RES_NONE;

    if (hit) begin
      res_o.ack_request = is_wheel;
      if (!enabled) begin
        if (is_wheel) begin
          wheel_t0_d  = t0;
          wheel_t1_d  = t1;
          wheel_seq_d = seq;
        end else begin
          speed_seq_d = seq;
        end
        do_disable                = 1'b1;
        res_o.clear_fault_mask[0] = |(clr & cfg_i.clear0_mask);
        res_o.clear_fault_mask[1] = |(clr & cfg_i.clear1_mask);
        comm_d                    = COMM_OK;
        res_o.frame_result        = RES_DISABLE;
      end else if (verdict == SEQ_PASS) begin
        if (is_wheel) begin
          wheel_t0_d  = t0;
          wheel_t1_d  = t1;
          wheel_seq_d = seq;
          mode_d      = MODE_CURRENT;
        end else begin
          speed_t0_d  = t0;
          speed_t1_d  = t1;
          speed_seq_d = seq;
          mode_d      = MODE_SPEED;
          res_o.reset_speed_mask[0] = (t0 == '0);
          res_o.reset_speed_mask[1] = (t1 == '0);
        end
        elapsed_d          = '0;
        comm_d             = COMM_OK;
        active_d           = 1'b1;
        res_o.frame_result = RES_ACCEPTED;
      end else if (verdict == SEQ_DUP) begin
        res_o.frame_result = RES_DUPLICATE;
      end else begin
        res_o.frame_result = RES_OUT_OF_ORDER;
      end
    end else if (item_i.op == OP_TICK && active_q) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc > cfg_i.timeout_ticks) begin
        do_disable = 1'b1;
        comm_d     = COMM_TIMEOUT;
      end else if (elapsed_inc > cfg_i.stale_ticks) begin
        comm_d = COMM_STALE;
      end else begin
        comm_d = COMM_OK;
      end
    end

    if (do_disable) begin
      speed_t0_d       = '0;
      speed_t1_d       = '0;
      mode_d           = MODE_CURRENT;
      res_o.force_zero = 1'b1;
      res_o.reset_all  = active_q;
      active_d         = 1'b0;
    end

    res_o.motor_mode      = mode_d;
    res_o.comm_status     = comm_d;
    res_o.command_active  = active_d;
    res_o.motor0_target   = (mode_d == MODE_SPEED) ? speed_t0_d : wheel_t0_d;
    res_o.motor1_target   = (mode_d == MODE_SPEED) ? speed_t1_d : wheel_t1_d;
    res_o.active_sequence = (mode_d == MODE_SPEED) ? speed_seq_d : wheel_seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CURRENT;
      comm_q      <= COMM_TIMEOUT;
      active_q    <= 1'b0;
      elapsed_q   <= '0;
      wheel_t0_q  <= '0;
      wheel_t1_q  <= '0;
      speed_t0_q  <= '0;
      speed_t1_q  <= '0;
      wheel_seq_q <= '0;
      speed_seq_q <= '0;
    end else if (commit_i) begin
      mode_q      <= mode_d;
      comm_q      <= comm_d;
      active_q    <= active_d;
      elapsed_q   <= elapsed_d;
      wheel_t0_q  <= wheel_t0_d;
      wheel_t1_q  <= wheel_t1_d;
      speed_t0_q  <= speed_t0_d;
      speed_t1_q  <= speed_t1_d;
      wheel_seq_q <= wheel_seq_d;
      speed_seq_q <= speed_seq_d;
    end
  end

  // forcing outputs to zero always drops back to current mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.force_zero |-> (res_o.motor_mode == MODE_CURRENT))
    else $error("force_zero without current mode");

  // a controller reset only comes with the command going inactive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.reset_all |-> (!res_o.command_active && res_o.force_zero))
    else $error("reset_all while command still active");

  // an active command never reports a timed-out link
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (comm_q != COMM_TIMEOUT))
    else $error("active command with comm timeout");

  // an accepted frame leaves the command active with a fresh watchdog
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && res_o.frame_result == RES_ACCEPTED) |=>
      (active_q && elapsed_q == '0))
    else $error("accepted frame did not arm the watchdog");

endmodule

// ----- hw/rtl/motor_command_frame_acceptor_core.sv -----
// ----------------------------------------------------------------------------
// motor_command_frame_acceptor_core: bus command frame acceptor
// Filters command frames, checks sequences, keeps targets and mode, and runs
// the comm watchdog on millisecond ticks. One result per frame or tick.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Transfer content
//  -----------  ---  ---------------------------------------------------------
//  s_axis_*     in   one frame or tick (tuser = op, tdata = frame fields)
//  m_axis_*     out  one result per input transfer, in input order
//  cfg_*        in   register write, index as listed in mcfa_pkg::cfg_idx_e
//
//  An input transfer is registered, decided from the input register and lands
//  in the output register once the output slot is free or drains.
//  One transfer per cycle is sustained while m_axis is not back-pressured; the
//  only loop is the command state update in mcfa_ctrl, a combinational path.
//  Back-pressure on m_axis stalls the input register, which still takes one
//  more transfer while the held result waits.
//  Reset clears all state at once; there is no clearing pass.
//
module motor_command_frame_acceptor_core
  import mcfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [10:0] frame_id, [14:11] frame_len, [46:15] payload_low,
  // [78:47] payload_high, [79] zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] op
  input  logic [0:0]          s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] frame_result, [3] ack_request, [4] motor_mode, [6:5] comm_status,
  // [7] command_active, [23:8] motor0_target, [39:24] motor1_target,
  // [55:40] active_sequence, [56] force_zero, [57] reset_all,
  // [59:58] reset_speed_mask, [61:60] clear_fault_mask, [63:62] zero fill
  output logic [OutDataW-1:0] m_axis_tdata,

  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q, in_valid_d;
  result_t res, out_q;
  logic    out_valid_q, out_valid_d;
  logic    advance, in_take;

  mcfa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the registered item moves on whenever the output slot is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.op           <= op_e'(s_axis_tuser[0]);
      in_item_q.frame_id     <= s_axis_tdata[10:0];
      in_item_q.frame_len    <= s_axis_tdata[14:11];
      in_item_q.payload_low  <= s_axis_tdata[46:15];
      in_item_q.payload_high <= s_axis_tdata[78:47];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  mcfa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .commit_i (advance),
    .item_i   (in_item_q),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00,
                          out_q.clear_fault_mask,
                          out_q.reset_speed_mask,
                          out_q.reset_all,
                          out_q.force_zero,
                          out_q.active_sequence,
                          out_q.motor1_target,
                          out_q.motor0_target,
                          out_q.command_active,
                          out_q.comm_status,
                          out_q.motor_mode,
                          out_q.ack_request,
                          out_q.frame_result};

endmodule
